@@ src/sorted_set_table_defines.svh @@
// Assertion helpers for the sorted set table
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// clocked check, quiet while reset is held
`define SST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, but also checked while reset is held
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sst_pkg.sv @@
package sst_pkg;

    localparam int WORD_W = 32;
    localparam int OUT_W  = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_UPD  = 4'b1000
    } sst_state_t;

    // broadcast to every cell
    typedef struct packed {
        logic cmp;        // latch compare flags
        logic scan;       // latch prefix flag
        logic shift_up;   // open a slot at the scan stop
        logic shift_down; // close the slot at the scan stop
    } cell_ctrl_t;

endpackage

@@ src/sst_cell.sv @@
module sst_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sst_pkg::cell_ctrl_t              ctrl,
    input  logic signed [sst_pkg::WORD_W-1:0] value,
    input  logic                             desc,
    input  logic signed [sst_pkg::WORD_W-1:0] left_entry,
    input  logic                             left_valid,
    input  logic                             left_lt,
    input  logic                             lt_in,
    input  logic signed [sst_pkg::WORD_W-1:0] right_entry,
    input  logic                             right_valid,
    output logic signed [sst_pkg::WORD_W-1:0] entry,
    output logic                             valid,
    output logic                             lt_out,
    output logic                             lt,
    output logic                             eq
);
    import sst_pkg::*;

    logic signed [WORD_W-1:0] entry_reg, entry_next;
    logic                     valid_reg, valid_next;
    logic                     b_reg, e_reg, lt_reg;
    logic                     before_w;
    logic                     stop_w;

    assign before_w = desc ? (entry_reg > value) : (entry_reg < value);
    assign lt_out   = lt_in & b_reg;
    // first cell not ordered before the value
    assign stop_w   = !lt_reg && left_lt;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.shift_up && !lt_reg)
        begin
            entry_next = stop_w ? value : left_entry;
            valid_next = left_valid;
        end
        else if (ctrl.shift_down && !lt_reg)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            b_reg     <= 1'b0;
            e_reg     <= 1'b0;
            lt_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp)
            begin
                b_reg <= valid_reg && before_w;
                e_reg <= valid_reg && (entry_reg == value);
            end
            if (ctrl.scan)
                lt_reg <= lt_out;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = e_reg;

endmodule

@@ src/sorted_set_table.sv @@
// Sorted set of up to DEPTH signed 32-bit words held in a row of DEPTH cells, one entry per
// cell, ascending or descending by cfg_wr_data. One item is in flight at a time: every cell
// compares its entry with the value, the "ordered before" flag ripples down the cell chain
// to find the stop position, and then the cells past the stop shift one place up (insert)
// or down (delete) together. After the item is accepted it passes the compare, scan and
// update states, and its result is presented in the same cycle as the block is ready for the
// next item, so no new item goes in before the current one has its result. A result that is
// not taken holds the block in its update cycle. No clearing pass after reset.
module sorted_set_table #(
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic signed [sst_pkg::WORD_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             accepted,
    output logic                             was_present,
    output logic [sst_pkg::OUT_W-1:0]        position,
    output logic [sst_pkg::OUT_W-1:0]        entry_count
);
    import sst_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    sst_state_t               state_reg, state_next;
    logic                     desc_reg;
    logic [1:0]               cmd_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic                     out_valid_reg;
    logic                     accepted_reg, accepted_next;
    logic                     present_reg;
    logic [OUT_W-1:0]         position_reg, count_out_reg;

    cell_ctrl_t               ctrl;
    logic signed [WORD_W-1:0] entry_w [DEPTH];
    logic [DEPTH-1:0]         valid_w, lt_w, eq_w, stop_w;
    logic [DEPTH:0]           chain_w;

    logic                     fire_upd, full, present;
    logic [CW-1:0]            pos;

    assign in_ready = (state_reg == ST_IDLE);
    assign fire_upd = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);
    assign full     = (count_reg == CW'(DEPTH));
    assign stop_w   = ~lt_w & {lt_w[DEPTH-2:0], 1'b1};
    assign present  = |(stop_w & eq_w);
    assign pos      = CW'($countones(lt_w));
    assign chain_w[0] = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_SCAN;
            ST_SCAN: state_next = ST_UPD;
            ST_UPD:  if (fire_upd) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.cmp      = (state_reg == ST_CMP);
        ctrl.scan     = (state_reg == ST_SCAN);
        accepted_next = 1'b0;
        count_next    = count_reg;
        case (cmd_reg)
            CMD_INSERT:
            begin
                accepted_next = !full;
                if (fire_upd && !full && !present)
                begin
                    ctrl.shift_up = 1'b1;
                    count_next    = count_reg + 1'b1;
                end
            end
            CMD_DELETE:
            begin
                accepted_next = present;
                if (fire_upd && present)
                begin
                    ctrl.shift_down = 1'b1;
                    count_next      = count_reg - 1'b1;
                end
            end
            CMD_LOOKUP: accepted_next = present;
            default:    accepted_next = 1'b0;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sst_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .value      (value_reg),
            .desc       (desc_reg),
            .left_entry ((i == 0) ? value_reg : entry_w[(i == 0) ? 0 : i - 1]),
            .left_valid ((i == 0) ? 1'b1 : valid_w[(i == 0) ? 0 : i - 1]),
            .left_lt    ((i == 0) ? 1'b1 : lt_w[(i == 0) ? 0 : i - 1]),
            .lt_in      (chain_w[i]),
            .right_entry((i == DEPTH - 1) ? value_reg : entry_w[(i == DEPTH - 1) ? i : i + 1]),
            .right_valid((i == DEPTH - 1) ? 1'b0 : valid_w[(i == DEPTH - 1) ? i : i + 1]),
            .entry      (entry_w[i]),
            .valid      (valid_w[i]),
            .lt_out     (chain_w[i+1]),
            .lt         (lt_w[i]),
            .eq         (eq_w[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
        if (fire_upd)
        begin
            accepted_reg  <= accepted_next;
            present_reg   <= present;
            position_reg  <= OUT_W'(pos);
            count_out_reg <= OUT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            desc_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
                desc_reg <= cfg_wr_data;
            if (fire_upd)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign was_present = present_reg;
    assign position    = position_reg;
    assign entry_count = count_out_reg;

endmodule

@@ src/sst_checker.sv @@
`include "sorted_set_table_defines.svh"

module sst_checker #(
    parameter int DEPTH = 64
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [sst_pkg::OUT_W-1:0] position,
    input logic [sst_pkg::OUT_W-1:0] entry_count
);
    import sst_pkg::*;

    // one item at a time: compare and scan cycles follow every accept
    `SST_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready ##1 !in_ready, "accepted during scan")

    `SST_ASSERT(a_count_bound, out_valid |-> (DEPTH > 127) || (entry_count <= OUT_W'(DEPTH)), "count beyond depth")

    `SST_ASSERT(a_pos_bound, out_valid |-> (DEPTH > 127) || (position <= entry_count), "position beyond count")

    `SST_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(position) && $stable(entry_count), "result dropped while stalled")

endmodule

bind sorted_set_table sst_checker #(.DEPTH(DEPTH)) u_sst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .position   (position),
    .entry_count(entry_count)
);

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int LONG_HOLD = 200;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

    typedef struct packed {
        logic             accepted;
        logic             was_present;
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] entry_count;
    } table_reply_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic                     cfg_wr_data = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               cmd = CMD_INSERT;
    logic signed [WORD_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     accepted;
    logic                     was_present;
    logic [OUT_W-1:0]         position;
    logic [OUT_W-1:0]         entry_count;

    // table contents as the block should hold them
    logic signed [WORD_W-1:0] shadow_entries [TABLE_DEPTH];
    int                       shadow_count = 0;
    bit                       shadow_desc = 1'b0;
    table_reply_t             pending_replies [$];
    int                       errors = 0;

    // sender and receiver pacing
    int                       gap_max = 6;
    int                       burst_left = 0;
    bit                       stall_on = 1'b1;
    logic [15:0]              ready_pattern = 16'hFFFF;
    int                       ready_phase = 0;
    int                       hold_left = 0;
    int                       holds_asked = 0;
    int                       holds_done = 0;

    sorted_set_table #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .was_present (was_present),
        .position    (position),
        .entry_count (entry_count)
    );

    always #10 clk = ~clk;

    function automatic bit sorts_ahead(logic signed [WORD_W-1:0] stored,
                                       logic signed [WORD_W-1:0] v);
        return shadow_desc ? (stored > v) : (stored < v);
    endfunction

    // scan, then update the shadow table; returns the reply the block owes
    function automatic table_reply_t apply_op(logic [1:0] op, logic signed [WORD_W-1:0] v);
        table_reply_t r;
        int           stop;
        int           n;
        bit           hit;
        n = shadow_count;
        stop = 0;
        while (stop < n && sorts_ahead(shadow_entries[stop], v))
            stop++;
        hit = (stop < n) && (shadow_entries[stop] == v);
        r.accepted = 1'b0;
        case (op)
            CMD_INSERT:
            begin
                // full refuses even a duplicate
                if (n < TABLE_DEPTH)
                begin
                    r.accepted = 1'b1;
                    if (!hit)
                    begin
                        for (int i = n; i > stop; i--)
                            shadow_entries[i] = shadow_entries[i-1];
                        shadow_entries[stop] = v;
                        n++;
                    end
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    r.accepted = 1'b1;
                    for (int i = stop; i + 1 < n; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    n--;
                end
            end
            CMD_LOOKUP:
                r.accepted = hit;
            default:
                r.accepted = 1'b0;
        endcase
        r.was_present = hit;
        r.position = OUT_W'(stop);
        r.entry_count = OUT_W'(n);
        shadow_count = n;
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        int unsigned r;
        int          near;
        r = $urandom_range(0, 99);
        if (r < 35 && shadow_count > 0)
            return shadow_entries[$urandom_range(0, shadow_count - 1)];
        if (r < 45 && shadow_count > 0)
            return shadow_entries[$urandom_range(0, shadow_count - 1)]
                   + ($urandom_range(0, 1) ? 1 : -1);
        if (r < 75)
        begin
            near = $urandom_range(0, 40);
            return near - 20;
        end
        if (r < 85)
        begin
            case ($urandom_range(0, 3))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_op(int ins_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return CMD_INSERT;
        if (r < ins_pct + (95 - ins_pct) / 2)
            return CMD_DELETE;
        if (r < 95)
            return CMD_LOOKUP;
        return CMD_NOP;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_item(input logic [1:0] op, input logic signed [WORD_W-1:0] v);
        int gap;
        if (gap_max > 0 && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        cmd <= op;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_replies.push_back(apply_op(op, v));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_order(input bit desc);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= desc;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_desc = desc;
    endtask

    // the front entry always stops the scan at 0, whatever the order
    task automatic drain_table();
        while (shadow_count > 0)
            send_item(CMD_DELETE, shadow_entries[0]);
        wait_idle();
    endtask

    task automatic test_random(input int count, input int ins_pct);
        repeat (count)
            send_item(pick_op(ins_pct), pick_value());
    endtask

    task automatic test_directed();
        send_item(CMD_LOOKUP, 0);
        send_item(CMD_DELETE, 5);
        send_item(CMD_NOP, 7);
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, WORD_MAX);
        send_item(CMD_INSERT, WORD_MIN);
        send_item(CMD_INSERT, -1);
        send_item(CMD_INSERT, 1);
        send_item(CMD_INSERT, WORD_MAX);
        send_item(CMD_LOOKUP, WORD_MIN);
        send_item(CMD_LOOKUP, WORD_MAX);
        send_item(CMD_LOOKUP, 2);
        send_item(CMD_NOP, -1);
        send_item(CMD_NOP, 3);
        send_item(CMD_DELETE, 2);
        send_item(CMD_DELETE, WORD_MIN);
        send_item(CMD_DELETE, WORD_MAX);
        send_item(CMD_DELETE, 0);
        send_item(CMD_LOOKUP, 0);
        send_item(CMD_INSERT, 32'h5555_5555);
        send_item(CMD_INSERT, 32'hAAAA_AAAA);
        drain_table();
    endtask

    task automatic test_full_table();
        while (shadow_count < TABLE_DEPTH)
            send_item(CMD_INSERT, $urandom());
        send_item(CMD_INSERT, shadow_entries[5]);
        send_item(CMD_INSERT, $urandom());
        send_item(CMD_LOOKUP, shadow_entries[TABLE_DEPTH-1]);
        send_item(CMD_NOP, shadow_entries[0]);
        send_item(CMD_DELETE, shadow_entries[TABLE_DEPTH-1]);
        send_item(CMD_INSERT, shadow_entries[0]);
        send_item(CMD_INSERT, WORD_MAX);
        send_item(CMD_INSERT, WORD_MIN);
    endtask

    // result side blocked for a long while; input must back up
    task automatic test_stalled_output();
        holds_asked++;
        repeat (12)
            send_item(pick_op(50), pick_value());
        wait_idle();
    endtask

    // order bit flipped on a populated table: entries stay where they are
    task automatic test_order_flip();
        wait_idle();
        write_order(!shadow_desc);
        test_random(25, 50);
        drain_table();
    endtask

    always @(posedge clk)
    begin
        if (holds_done != holds_asked)
        begin
            holds_done = holds_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (ready_phase == 0)
                ready_pattern = $urandom_range(0, 3) == 0 ? 16'($urandom() & $urandom())
                                                          : 16'($urandom() | $urandom());
            out_ready <= !stall_on || ready_pattern[ready_phase];
            ready_phase = (ready_phase + 1) % 16;
        end
    end

    always @(posedge clk)
    begin : reply_check
        table_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unrequested item, expected none, got %b %b %0d %0d",
                         $time, accepted, was_present, position, entry_count);
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("accepted", want.accepted, accepted);
                check_field("was_present", want.was_present, was_present);
                check_field("position", want.position, position);
                check_field("entry_count", want.entry_count, entry_count);
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_order(1'b0);
        test_directed();
        test_full_table();
        drain_table();
        write_order(1'b1);
        test_random(50, 70);
        test_stalled_output();
        test_random(40, 35);
        test_order_flip();
        write_order(1'b0);
        // back-to-back stretch, no idling on either side
        gap_max = 0;
        stall_on = 1'b0;
        test_random(40, 60);
        gap_max = 6;
        stall_on = 1'b1;
        test_random(60, 40);
        drain_table();
        write_order(1'b1);
        test_full_table();
        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_replies.size() == 0)
            $display("PASS sorted_set_table");
        else
            $display("FAIL sorted_set_table");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL sorted_set_table");
        $finish;
    end

endmodule
